FILE: rtl/rllt_pkg.sv
package rllt_pkg;

	localparam int MAX_RUNS_DEF  = 256;
	localparam int LINE_BITS_DEF = 16;
	localparam int LEN_W         = 16;
	localparam int OFF_W         = 16;
	localparam int LINE_IN_W     = 16;
	localparam int LINE_OUT_W    = 16;
	localparam logic [LEN_W-1:0] RUN_LEN_MAX = '1;

	typedef enum logic {
		FN_APPEND = 1'b0,
		FN_LOOKUP = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		func_t                func;
		logic [LINE_IN_W-1:0] line_number;
		logic [OFF_W-1:0]     byte_offset;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [LINE_OUT_W-1:0] found_line;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPEND,
		S_LK_FIRST,
		S_LK_WALK,
		S_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic append;
		logic lk_first;
		logic lk_step;
		logic push_out;
	} cmd_t;

	typedef struct packed {
		logic lookup;
		logic empty;
		logic hit;
		logic at_last;
	} sts_t;

endpackage

FILE: rtl/rllt_ctrl.sv
module rllt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  rllt_pkg::sts_t       sts,
	output rllt_pkg::cmd_t       cmd,
	output rllt_pkg::ctrl_state_t state
);
	import rllt_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = sts.lookup ? S_LK_FIRST : S_APPEND;
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d    = S_RESULT;
			end
			S_LK_FIRST: begin
				cmd.lk_first = 1'b1;
				state_d      = sts.empty ? S_RESULT : S_LK_WALK;
			end
			S_LK_WALK: begin
				cmd.lk_step = 1'b1;
				if (sts.hit || sts.at_last) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.push_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign state     = state_q;

endmodule

FILE: rtl/rllt_dp.sv
module rllt_dp #(
	parameter int MAX_RUNS  = rllt_pkg::MAX_RUNS_DEF,
	parameter int LINE_BITS = rllt_pkg::LINE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rllt_pkg::req_t req,
	output rllt_pkg::rsp_t rsp,
	input  rllt_pkg::cmd_t cmd,
	output rllt_pkg::sts_t sts
);
	import rllt_pkg::*;

	localparam int IdxW = $clog2(MAX_RUNS);
	localparam int CntW = $clog2(MAX_RUNS + 1);

	// Run store: one write port, one registered read port.
	logic [LINE_BITS-1:0] line_mem [MAX_RUNS];
	logic [LEN_W-1:0]     len_mem  [MAX_RUNS];

	logic [CntW-1:0]      count_q;
	logic [LINE_BITS-1:0] last_line_q;
	logic [LEN_W-1:0]     last_len_q;
	logic [LINE_BITS-1:0] line_q;
	logic [OFF_W-1:0]     left_q;
	logic [IdxW-1:0]      idx_q;
	logic [LINE_BITS-1:0] rd_line_q;
	logic [LEN_W-1:0]     rd_len_q;
	rsp_t                 res_q;
	rsp_t                 out_q;

	logic            extend;
	logic            full;
	logic            wr_en;
	logic [IdxW-1:0] wr_addr;
	logic [LEN_W-1:0] wr_len;
	logic [IdxW-1:0] rd_addr;
	logic [CntW-1:0] count_last;

	assign full       = (count_q == CntW'(MAX_RUNS));
	assign count_last = count_q - CntW'(1);
	assign extend     = (count_q != '0) && (last_line_q == line_q) &&
	                    (last_len_q != RUN_LEN_MAX);
	assign wr_en      = cmd.append && (extend || !full);
	assign wr_addr    = extend ? count_last[IdxW-1:0] : count_q[IdxW-1:0];
	assign wr_len     = extend ? LEN_W'(last_len_q + LEN_W'(1)) : LEN_W'(1);
	assign rd_addr    = cmd.lk_step ? IdxW'(idx_q + IdxW'(1)) : '0;

	assign sts.lookup  = (req.func == FN_LOOKUP);
	assign sts.empty   = (count_q == '0);
	assign sts.hit     = (rd_len_q > left_q);
	assign sts.at_last = ((CntW'(idx_q) + CntW'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= line_q;
			len_mem[wr_addr]  <= wr_len;
		end
		rd_line_q <= line_mem[rd_addr];
		rd_len_q  <= len_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en && !extend) begin
			count_q <= count_q + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			line_q <= LINE_BITS'(req.line_number);
			left_q <= req.byte_offset;
		end
		if (wr_en) begin
			last_line_q <= line_q;
			last_len_q  <= wr_len;
		end
		if (cmd.lk_first) begin
			idx_q <= '0;
		end else if (cmd.lk_step) begin
			idx_q  <= IdxW'(idx_q + IdxW'(1));
			left_q <= left_q - rd_len_q;
		end
		if (cmd.append) begin
			res_q.status     <= (!extend && full) ? ST_FULL : ST_OK;
			res_q.found_line <= '0;
		end else if (cmd.lk_first && sts.empty) begin
			res_q.status     <= ST_NOT_FOUND;
			res_q.found_line <= '0;
		end else if (cmd.lk_step && sts.hit) begin
			res_q.status     <= ST_OK;
			res_q.found_line <= LINE_OUT_W'(rd_line_q);
		end else if (cmd.lk_step && sts.at_last) begin
			res_q.status     <= ST_NOT_FOUND;
			res_q.found_line <= '0;
		end
		if (cmd.push_out) begin
			out_q <= res_q;
		end
	end

	assign rsp = out_q;

endmodule

FILE: rtl/run_length_line_table_unit.sv
// Channel   Direction  Handshake              Payload
// req       input      req_valid / req_ready  rllt_pkg::req_t (func, line_number, byte_offset)
// rsp       output     rsp_valid / rsp_ready  rllt_pkg::rsp_t (status, found_line)
//
// An append goes through the append state and the result state before its result
// is registered on rsp; the block is back in the idle state, ready for the next transaction, as the result appears.
// A lookup goes through the first-read state, one walk step per run visited (none
// on an empty table, at most MAX_RUNS) and the result state; the walk reads one run
// per cycle from the single read port of the run memory, with the compare and
// subtract of the previous run overlapped.
// Reset clears the run count, the controller state and the response valid flag; the run memory needs no clearing pass.
// A result waiting on rsp does not stop the next transaction from being taken;
// only a second finished result waits until the output register frees up.
module run_length_line_table_unit #(
	parameter int MAX_RUNS  = rllt_pkg::MAX_RUNS_DEF,
	parameter int LINE_BITS = rllt_pkg::LINE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rllt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rllt_pkg::rsp_t rsp
);
	import rllt_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	ctrl_state_t state;

	// The controller sequences each transaction; it never touches the payload.
	rllt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	// The datapath holds the run memory, the last-run copy used by appends,
	// the lookup walk registers and the output register.
	rllt_dp #(
		.MAX_RUNS  (MAX_RUNS),
		.LINE_BITS (LINE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

	// Once a transaction is taken, the block is busy until its result is staged.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while previous one still in flight");

	// A new result is never written over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_out |-> (!rsp_valid || rsp_ready))
		else $error("pending response overwritten");

	// Every staged result shows up on the response channel.
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_out |=> rsp_valid)
		else $error("staged response not presented");

	// A walk always ends on a hit or at the last stored run.
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_LK_WALK && (sts.hit || sts.at_last)) |=> state == S_RESULT)
		else $error("lookup walk did not finish");

endmodule

FILE: sim/run_length_line_table_unit_tb.sv
`timescale 1ns / 1ps

module run_length_line_table_unit_tb;

	import rllt_pkg::*;

	localparam int RUNS        = MAX_RUNS_DEF;
	localparam int OFFSET_MAX  = (1 << OFF_W) - 1;
	// The slowest transaction is a full-table walk, and stalls on both sides
	// can lengthen it further; about a thousand of them still end well inside
	// this limit.
	localparam int CYCLE_LIMIT = 4_000_000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Shadow copy of the run table. Only entries below run_total are ever read.
	logic [LINE_IN_W-1:0] line_of_run [RUNS];
	logic [LEN_W-1:0]     len_of_run [RUNS];
	int                   run_total;
	int                   byte_total;

	// Results that the table is owed, oldest first.
	rsp_t expected_q [$];

	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count;
	int error_count;
	int n_appends;
	int n_dropped;
	int n_lookups;
	int n_missed;
	int n_checked;

	run_length_line_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// The receiver stalls on a random share of cycles; with a zero share it
	// is always ready.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Applies one transaction to the shadow table and returns the result that
	// the block has to produce for it.
	function automatic rsp_t table_apply(input req_t item);
		rsp_t res;
		int   left;
		int   idx;
		res.status     = ST_OK;
		res.found_line = '0;
		if (item.func == FN_APPEND) begin
			n_appends++;
			// A matching line extends the last run, unless that run is
			// already as long as a run can be; then a new run is needed.
			if (run_total != 0 && line_of_run[run_total-1] == item.line_number
					&& len_of_run[run_total-1] != RUN_LEN_MAX) begin
				len_of_run[run_total-1]++;
				byte_total++;
			end else if (run_total == RUNS) begin
				res.status = ST_FULL;
				n_dropped++;
			end else begin
				line_of_run[run_total] = item.line_number;
				len_of_run[run_total]  = LEN_W'(1);
				run_total++;
				byte_total++;
			end
		end else begin
			n_lookups++;
			// Walk the runs from the first, eating each run's length off the
			// offset until one run covers what is left.
			left       = int'(item.byte_offset);
			idx        = 0;
			res.status = ST_NOT_FOUND;
			while (idx < run_total && res.status == ST_NOT_FOUND) begin
				if (int'(len_of_run[idx]) > left) begin
					res.status     = ST_OK;
					res.found_line = line_of_run[idx];
				end else begin
					left -= int'(len_of_run[idx]);
				end
				idx++;
			end
			if (res.status == ST_NOT_FOUND)
				n_missed++;
		end
		return res;
	endfunction

	function automatic logic [OFF_W-1:0] clamp_offset(input int value);
		if (value < 0)
			return '0;
		if (value > OFFSET_MAX)
			return OFF_W'(OFFSET_MAX);
		return OFF_W'(value);
	endfunction

	task automatic flag_mismatch(input string what, input int want, input int got);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Result checker. rsp_ready only moves right after a rising edge, so a
	// result that is valid and ready at the falling edge is taken at the next
	// rising edge; sampling here keeps the check clear of any race at the edge.
	always @(negedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			n_checked++;
			if (expected_q.size() == 0) begin
				flag_mismatch("unexpected result, status", -1, rsp.status);
			end else begin
				want = expected_q.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch("status", want.status, rsp.status);
				if (rsp.found_line !== want.found_line)
					flag_mismatch("found_line", want.found_line, rsp.found_line);
			end
		end
	end

	// Sends one transaction. The sender may first idle for some cycles; valid
	// then stays high with a fixed payload until req_ready is seen. The
	// expectation is queued at the falling edge just before the accepting edge.
	task automatic send_item(input req_t item);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do begin
			@(negedge clk);
			taken = (req_ready === 1'b1);
			if (taken)
				expected_q.push_back(table_apply(item));
			@(posedge clk);
		end while (!taken);
	endtask

	// The unused field of each transaction carries noise, which the block
	// has to ignore.
	task automatic send_append(input logic [LINE_IN_W-1:0] line);
		req_t item;
		item.func        = FN_APPEND;
		item.line_number = line;
		item.byte_offset = OFF_W'($urandom());
		send_item(item);
	endtask

	task automatic send_lookup(input int offset);
		req_t item;
		item.func        = FN_LOOKUP;
		item.line_number = LINE_IN_W'($urandom());
		item.byte_offset = clamp_offset(offset);
		send_item(item);
	endtask

	// Drops valid and holds off until every outstanding result has come back.
	// The task always waits on the clock before it returns, so valid is never
	// lowered and raised in the same time step.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_q.size() != 0);
	endtask

	// Lookups on an empty table, the first append, extension of the last run,
	// and offsets on both sides of the end of the table.
	task automatic test_empty_table();
		send_idle_pct = 17;
		recv_idle_pct = 48;
		send_lookup(0);
		send_lookup(OFFSET_MAX);
		send_append(16'h0000);
		send_lookup(0);
		send_lookup(1);
		send_append(16'h0000);
		send_lookup(1);
		send_lookup(2);
	endtask

	// New runs for each change of line, including a return to a line that an
	// older run already holds, then lookups at each run boundary.
	task automatic test_run_extension();
		send_append(16'hFFFF);
		send_append(16'hFFFF);
		send_append(16'h5A5A);
		send_append(16'hA5A5);
		send_append(16'h0000);
		send_lookup(1);
		send_lookup(2);
		send_lookup(3);
		send_lookup(4);
		send_lookup(5);
		send_lookup(6);
		send_lookup(7);
		send_lookup(OFFSET_MAX);
	endtask

	// Random traffic. An append that does not draw a fresh line repeats the
	// last line so that runs grow long; fresh_pct sets how often a new line
	// starts a run. Lookup offsets mix fully random values, values up to just
	// past the end of the table, values right at run edges and small values.
	task automatic test_random_traffic(input int items, input int send_pct,
			input int recv_pct, input int fresh_pct);
		req_t item;
		int   pick;
		int   edge_run;
		int   edge_at;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (items) begin
			// Now and then the sender waits for the pipeline to drain.
			if ($urandom_range(99) == 0)
				wait_drained();
			item.line_number = LINE_IN_W'($urandom());
			item.byte_offset = OFF_W'($urandom());
			if ($urandom_range(99) < 45) begin
				item.func = FN_LOOKUP;
				pick      = $urandom_range(3);
				if (pick == 1) begin
					item.byte_offset = clamp_offset($urandom_range(0,
						(byte_total + 2 > OFFSET_MAX) ? OFFSET_MAX : byte_total + 2));
				end else if (pick == 2) begin
					edge_run = $urandom_range(0, run_total);
					edge_at  = 0;
					for (int k = 0; k < edge_run; k++)
						edge_at += int'(len_of_run[k]);
					item.byte_offset = clamp_offset(edge_at - int'($urandom_range(0, 1)));
				end else if (pick == 3) begin
					item.byte_offset = OFF_W'($urandom_range(0, 15));
				end
			end else begin
				item.func = FN_APPEND;
				if (run_total != 0 && $urandom_range(99) >= fresh_pct)
					item.line_number = line_of_run[run_total-1];
			end
			send_item(item);
		end
	endtask

	// Fills every remaining run slot with a new line, then checks that a
	// further new run is refused while the last run can still grow. The
	// sender first waits until every earlier result is back.
	task automatic test_table_full();
		logic [LINE_IN_W-1:0] next_line;
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		next_line = line_of_run[run_total-1];
		while (run_total < RUNS) begin
			next_line++;
			send_append(next_line);
		end
		send_append(next_line + LINE_IN_W'(1));
		send_append(16'h0000);
		send_append(next_line);
		send_lookup(0);
		send_lookup(int'($urandom_range(0, OFFSET_MAX)));
		send_lookup(OFFSET_MAX);
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		cycle_count   = 0;
		error_count   = 0;
		n_appends     = 0;
		n_dropped     = 0;
		n_lookups     = 0;
		n_missed      = 0;
		n_checked     = 0;
		run_total     = 0;
		byte_total    = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		rsp_ready <= 1'b0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_run_extension();
		test_random_traffic(250, 17, 48, 25);
		test_random_traffic(250, 48, 17, 25);
		test_random_traffic(200, 0, 0, 60);
		test_table_full();

		// A lookup can walk every run, so give any stray result time to show.
		wait_drained();
		repeat (RUNS + 16)
			@(posedge clk);

		$display("Checked %0d results: %0d appends (%0d refused on a full table),",
			n_checked, n_appends, n_dropped);
		$display("%0d lookups (%0d past the end); %0d runs over %0d bytes; %0d mismatches.",
			n_lookups, n_missed, run_total, byte_total, error_count);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/rllt_pkg.sv
rtl/rllt_ctrl.sv
rtl/rllt_dp.sv
rtl/run_length_line_table_unit.sv
sim/run_length_line_table_unit_tb.sv
